// ===== hw/rtl/humidity_temp_frame_decoder_top_assert.svh =====
// Assertion macros for the frame decoder.
// Included by the RTL files that carry concurrent checks; needs clk and rst_n in scope.
`ifndef HUMIDITY_TEMP_FRAME_DECODER_TOP_ASSERT_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define HTFD_ASSERT_IMPL(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error("htfd check failed");
`define HTFD_ASSERT_NEXT(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error("htfd check failed");
`else
`define HTFD_ASSERT_IMPL(lbl, ant, cons)
`define HTFD_ASSERT_NEXT(lbl, ant, cons)
`endif
`endif

// ===== hw/rtl/htfd_pkg.sv =====
// Shared types, constants and the CRC-8 byte function for the frame decoder.
// No dependencies.
package htfd_pkg;

    localparam logic [7:0]  CRC_POLY     = 8'h31;
    localparam logic [7:0]  RAW_LOW_MASK = 8'hFC;
    localparam int          TYPE_BIT     = 1;

    localparam logic [14:0] TEMP_SCALE   = 15'd17572;
    localparam logic [14:0] HUM_SCALE    = 15'd12500;
    localparam logic [15:0] TEMP_OFFSET  = 16'd4685;
    localparam logic [15:0] HUM_OFFSET   = 16'd600;

    localparam logic [1:0]  STATUS_OK    = 2'd0;
    localparam logic [1:0]  STATUS_TYPE  = 2'd1;
    localparam logic [1:0]  STATUS_CRC   = 2'd2;

    typedef struct packed {
        logic valid;
        logic hum;
    } htfd_ctl_t;

    // One byte through an MSB-first CRC-8, no reflection.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/humidity_temp_frame_decoder_top.sv =====
// Frame decoder top level: type check, CRC-8 check and conversion pipeline.
// Depends on htfd_pkg, htfd_scale and humidity_temp_frame_decoder_top_assert.svh.
//
// Usage:
//   Drive command, frame_msb, frame_lsb and frame_crc with start high; the
//   transaction is taken at that clock edge when busy is low. busy stays low,
//   so a new frame can be started in every cycle.
//   When a taken frame leaves stage 3, done is high for exactly one cycle
//   with status and reading for that frame. Frames come out in order.
//   Stage 1 registers the frame, runs the CRC over the first byte and checks
//   the type flag; stage 2 finishes the CRC, decides status and multiplies the
//   raw value by the scale; stage 3 shifts, removes the offset and registers
//   the result. The 15x16 multiply sets the stage depth.
//   Throughput: one frame per cycle.
//   reading is 0 whenever status is not ok; type mismatch wins over CRC error.
//   The receiver cannot stall: a result is valid only in its done cycle.
//   Reset clears all valid bits; nothing else needs reset and no clearing
//   pass is done.
module humidity_temp_frame_decoder_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        command,
    input  logic [7:0]  frame_msb,
    input  logic [7:0]  frame_lsb,
    input  logic [7:0]  frame_crc,
    output logic        done,
    output logic [1:0]  status,
    output logic signed [14:0] reading
);
    import htfd_pkg::*;

    logic        s1_valid_reg;
    logic        s1_hum_reg;
    logic        s1_type_ok_reg;
    logic [7:0]  s1_crc_reg;
    logic [7:0]  s1_lsb_reg;
    logic [7:0]  s1_rx_reg;
    logic [7:0]  s1_raw_hi_reg;
    logic [15:0] s1_raw;

    logic        s2_valid_reg;
    logic [1:0]  s2_status_reg;
    logic [1:0]  s2_status_next;
    logic [7:0]  s2_crc;

    logic        s3_valid_reg;
    logic        s3_hum_reg;
    logic        s2_hum_reg;
    logic [1:0]  s3_status_reg;
    logic [14:0] scaled;

    htfd_ctl_t   scale_ctl;

    assign busy = 1'b0;

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // stage 1: first CRC byte and type flag
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            s1_hum_reg     <= command;
            s1_type_ok_reg <= (frame_lsb[TYPE_BIT] == command);
            s1_crc_reg     <= crc8_byte(8'h00, frame_msb);
            s1_lsb_reg     <= frame_lsb;
            s1_rx_reg      <= frame_crc;
            s1_raw_hi_reg  <= frame_msb;
        end
    end

    assign s1_raw = {s1_raw_hi_reg, s1_lsb_reg & RAW_LOW_MASK};

    // stage 2: second CRC byte and status
    assign s2_crc = crc8_byte(s1_crc_reg, s1_lsb_reg);

    always_comb
    begin
        if (!s1_type_ok_reg)
            s2_status_next = STATUS_TYPE;
        else if (s2_crc != s1_rx_reg)
            s2_status_next = STATUS_CRC;
        else
            s2_status_next = STATUS_OK;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_status_reg <= s2_status_next;
            s2_hum_reg    <= s1_hum_reg;
        end
        if (s2_valid_reg)
        begin
            s3_status_reg <= s2_status_reg;
            s3_hum_reg    <= s2_hum_reg;
        end
    end

    assign scale_ctl.valid = s1_valid_reg;
    assign scale_ctl.hum   = s1_hum_reg;

    htfd_scale u_scale (
        .clk    (clk),
        .ctl    (scale_ctl),
        .raw    (s1_raw),
        .scaled (scaled)
    );

    assign done    = s3_valid_reg;
    assign status  = s3_status_reg;
    assign reading = (s3_status_reg == STATUS_OK) ? $signed(scaled) : 15'sd0;

`include "humidity_temp_frame_decoder_top_assert.svh"

    `HTFD_ASSERT_IMPL(a_err_reads_zero, done && status != STATUS_OK, reading == 15'sd0)
    `HTFD_ASSERT_NEXT(a_valid_chain, s1_valid_reg, s2_valid_reg)
    `HTFD_ASSERT_IMPL(a_hum_range, done && status == STATUS_OK && s3_hum_reg,
                      reading >= -15'sd600 && reading <= 15'sd11899)
    `HTFD_ASSERT_IMPL(a_temp_range, done && status == STATUS_OK && !s3_hum_reg,
                      reading >= -15'sd4685 && reading <= 15'sd12885)

endmodule

// ===== hw/rtl/htfd_scale.sv =====
// Two-stage fixed-point conversion of the 16-bit raw value: multiply, then shift and offset.
// Depends on htfd_pkg.
module htfd_scale (
    input  logic                clk,
    input  htfd_pkg::htfd_ctl_t ctl,
    input  logic [15:0]         raw,
    output logic [14:0]         scaled
);
    import htfd_pkg::*;

    logic [30:0] prod_reg;
    logic [30:0] prod_next;
    logic        hum_reg;
    logic [14:0] scaled_reg;
    logic [14:0] scaled_next;
    logic [15:0] offset;
    logic [15:0] diff;

    assign prod_next = 31'(raw) * 31'(ctl.hum ? HUM_SCALE : TEMP_SCALE);

    always_ff @(posedge clk)
    begin
        if (ctl.valid)
        begin
            prod_reg <= prod_next;
            hum_reg  <= ctl.hum;
        end
    end

    // drop the 16 fraction bits, then remove the offset
    assign offset      = hum_reg ? HUM_OFFSET : TEMP_OFFSET;
    assign diff        = {1'b0, prod_reg[30:16]} - offset;
    assign scaled_next = diff[14:0];

    always_ff @(posedge clk)
    begin
        scaled_reg <= scaled_next;
    end

    assign scaled = scaled_reg;

endmodule

// ===== test/htfd_tb_pkg.sv =====
`timescale 1ns / 1ps
// Frame CRC helper shared by the frame decoder testbench and its checker.
// No dependencies.
package htfd_tb_pkg;

    localparam logic [7:0] FRAME_CRC_POLY = 8'h31;

    // Bit-serial CRC-8 over MSB then LSB, starting from zero.
    function automatic logic [7:0] frame_crc8(input logic [7:0] msb, input logic [7:0] lsb);
        logic [15:0] bits;
        logic [7:0]  c;
        logic        fb;
        bits = {msb, lsb};
        c = 8'h00;
        for (int i = 15; i >= 0; i--)
        begin
            fb = c[7] ^ bits[i];
            c = {c[6:0], 1'b0} ^ (fb ? FRAME_CRC_POLY : 8'h00);
        end
        return c;
    endfunction

endpackage

// ===== test/htfd_checker.sv =====
`timescale 1ns / 1ps
// Checker for the frame decoder: predicts status and reading for every accepted
// frame and compares against each done strobe. Depends on htfd_pkg and htfd_tb_pkg.
module htfd_checker
    import htfd_pkg::*;
    import htfd_tb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               command,
    input  logic [7:0]         frame_msb,
    input  logic [7:0]         frame_lsb,
    input  logic [7:0]         frame_crc,
    input  logic               done,
    input  logic [1:0]         status,
    input  logic signed [14:0] reading,
    output int                 error_count,
    output int                 pending,
    output int                 results_checked
);

    localparam longint TEMP_MUL  = 17572;
    localparam longint TEMP_BIAS = 4685;
    localparam longint HUM_MUL   = 12500;
    localparam longint HUM_BIAS  = 600;
    localparam int     MAX_REPORTS = 10;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [14:0] reading;
    } decoded_t;

    decoded_t decoded_q[$];
    decoded_t want;

    function automatic decoded_t decode_frame(input logic cmd, input logic [7:0] msb,
                                              input logic [7:0] lsb, input logic [7:0] crc);
        decoded_t    d;
        logic [15:0] raw;
        longint      value;
        d.status  = STATUS_OK;
        d.reading = '0;
        // Type flag is checked first; a wrong type hides a bad CRC.
        if (lsb[1] != cmd)
            d.status = STATUS_TYPE;
        else if (frame_crc8(msb, lsb) != crc)
            d.status = STATUS_CRC;
        else
        begin
            raw = {msb, lsb[7:2], 2'b00};
            if (cmd)
                value = ((longint'(raw) * HUM_MUL) >>> 16) - HUM_BIAS;
            else
                value = ((longint'(raw) * TEMP_MUL) >>> 16) - TEMP_BIAS;
            d.reading = value[14:0];
        end
        return d;
    endfunction

    function automatic void report_error(input string msg);
        if (error_count < MAX_REPORTS)
            $display("[%0t] checker: %s", $realtime, msg);
        error_count++;
    endfunction

    initial
    begin
        error_count     = 0;
        pending         = 0;
        results_checked = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done === 1'b1)
            begin
                results_checked++;
                if (decoded_q.size() == 0)
                    report_error($sformatf("result with nothing outstanding: status %0d reading %0d",
                                           status, reading));
                else
                begin
                    want = decoded_q.pop_front();
                    if (status !== want.status || reading !== want.reading)
                        report_error($sformatf(
                            "mismatch: status exp %0d got %0d, reading exp %0d got %0d",
                            want.status, status, want.reading, reading));
                end
            end
            if (start && !busy)
                decoded_q.push_back(decode_frame(command, frame_msb, frame_lsb, frame_crc));
            pending = decoded_q.size();
        end
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for humidity_temp_frame_decoder_top: directed and random frames
// with random start gaps. Depends on htfd_pkg, htfd_tb_pkg and htfd_checker.
module tb;
    import htfd_pkg::*;
    import htfd_tb_pkg::*;

    localparam int RANDOM_FRAMES = 800;
    localparam int MAX_GAP       = 12;
    localparam int DRAIN_CYCLES  = 12;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               command = 1'b0;
    logic [7:0]         frame_msb = 8'h00;
    logic [7:0]         frame_lsb = 8'h00;
    logic [7:0]         frame_crc = 8'h00;
    logic               done;
    logic [1:0]         status;
    logic signed [14:0] reading;

    int error_count;
    int pending;
    int results_checked;
    int sent_good;
    int sent_type_err;
    int sent_crc_err;

    humidity_temp_frame_decoder_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .command   (command),
        .frame_msb (frame_msb),
        .frame_lsb (frame_lsb),
        .frame_crc (frame_crc),
        .done      (done),
        .status    (status),
        .reading   (reading)
    );

    htfd_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .command         (command),
        .frame_msb       (frame_msb),
        .frame_lsb       (frame_lsb),
        .frame_crc       (frame_crc),
        .done            (done),
        .status          (status),
        .reading         (reading),
        .error_count     (error_count),
        .pending         (pending),
        .results_checked (results_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #1ms;
        $display("timeout: %0d results still outstanding", pending);
        $display("TEST FAILED");
        $finish;
    end

    // Hold the frame with start high until an edge takes it.
    task automatic send_frame(input logic cmd, input logic [7:0] msb, input logic [7:0] lsb,
                              input logic [7:0] crc, input int gap);
        logic was_busy;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        command   <= cmd;
        frame_msb <= msb;
        frame_lsb <= lsb;
        frame_crc <= crc;
        do
        begin
            @(negedge clk);
            was_busy = busy;
            @(posedge clk);
        end while (was_busy);
        if (lsb[1] != cmd)
            sent_type_err++;
        else if (frame_crc8(msb, lsb) != crc)
            sent_crc_err++;
        else
            sent_good++;
    endtask

    // Well-formed frame: type flag matches the command, CRC is correct.
    task automatic send_valid(input logic cmd, input logic [7:0] msb, input logic [7:0] lsb,
                              input int gap);
        logic [7:0] b;
        b = lsb;
        b[1] = cmd;
        send_frame(cmd, msb, b, frame_crc8(msb, b), gap);
    endtask

    initial
    begin
        int         kind;
        int         gap_mode;
        int         gap;
        logic       cmd;
        logic [7:0] msb;
        logic [7:0] lsb;
        logic [7:0] crc;

        sent_good     = 0;
        sent_type_err = 0;
        sent_crc_err  = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Range ends of both conversions, reserved bit set and clear.
        send_valid(1'b0, 8'h00, 8'h00, 0);
        send_valid(1'b0, 8'h00, 8'h01, 0);
        send_valid(1'b0, 8'hFF, 8'hFC, 0);
        send_valid(1'b0, 8'hFF, 8'hFD, 0);
        send_valid(1'b0, 8'h80, 8'h00, 3);
        send_valid(1'b1, 8'h00, 8'h02, 0);
        send_valid(1'b1, 8'h00, 8'h03, 0);
        send_valid(1'b1, 8'hFF, 8'hFE, 0);
        send_valid(1'b1, 8'hFF, 8'hFF, 1);
        send_valid(1'b1, 8'h80, 8'h02, 0);
        send_valid(1'b0, 8'h44, 8'h44, 0);
        // Wrong type with good CRC, then with bad CRC as well.
        send_frame(1'b0, 8'h12, 8'h02, frame_crc8(8'h12, 8'h02), 0);
        send_frame(1'b1, 8'h12, 8'h00, frame_crc8(8'h12, 8'h00), 0);
        send_frame(1'b0, 8'hFF, 8'hFF, 8'h00, 2);
        send_frame(1'b1, 8'h00, 8'h00, 8'hFF, 0);
        // CRC off by single bits and by all bits.
        send_frame(1'b0, 8'h66, 8'h64, frame_crc8(8'h66, 8'h64) ^ 8'h01, 0);
        send_frame(1'b1, 8'h66, 8'h66, frame_crc8(8'h66, 8'h66) ^ 8'h80, 0);
        send_frame(1'b0, 8'h00, 8'h00, 8'hFF, 0);
        send_frame(1'b1, 8'hFF, 8'hFF, ~frame_crc8(8'hFF, 8'hFF), 5);

        gap_mode = 0;
        for (int n = 0; n < RANDOM_FRAMES; n++)
        begin
            // Switch between back-to-back runs and gapped runs every 40 frames.
            if (n % 40 == 0)
                gap_mode = $urandom_range(0, 2);
            if (gap_mode == 0)
                gap = 0;
            else if (gap_mode == 1)
                gap = $urandom_range(0, MAX_GAP);
            else
                gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, MAX_GAP);

            kind = $urandom_range(0, 99);
            cmd  = 1'($urandom_range(0, 1));
            msb  = 8'($urandom_range(0, 255));
            lsb  = 8'($urandom_range(0, 255));
            if (kind < 70)
                send_valid(cmd, msb, lsb, gap);
            else if (kind < 85)
            begin
                lsb[1] = ~cmd;
                crc = ($urandom_range(0, 1) == 0) ? frame_crc8(msb, lsb)
                                                  : 8'($urandom_range(0, 255));
                send_frame(cmd, msb, lsb, crc, gap);
            end
            else
            begin
                lsb[1] = cmd;
                crc = frame_crc8(msb, lsb) ^ 8'($urandom_range(1, 255));
                send_frame(cmd, msb, lsb, crc, gap);
            end
        end
        start <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Drove %0d frames: %0d well-formed, %0d wrong type, %0d bad CRC.",
                 sent_good + sent_type_err + sent_crc_err, sent_good, sent_type_err,
                 sent_crc_err);
        $display("Compared %0d results, %0d errors, %0d left outstanding.",
                 results_checked, error_count, pending);
        if (error_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
